// File: hw/rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Types, character codes, format codes and the power-of-ten table shared by
// the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned SHIFT_W   = 2;

    localparam logic [IDX_W-1:0] IDX_LAST  = 4'd9;
    localparam logic [IDX_W-1:0] IDX_S8    = 4'd7;
    localparam logic [IDX_W-1:0] IDX_S16   = 4'd5;
    localparam logic [IDX_W-1:0] IDX_S32   = 4'd0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [OP_W-1:0] {
        OP_U8    = 3'd0,
        OP_S8    = 3'd1,
        OP_U16   = 3'd2,
        OP_S16   = 3'd3,
        OP_U32   = 3'd4,
        OP_S32   = 3'd5,
        OP_UFREE = 3'd6,
        OP_SFREE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SIGN = 2'd1,
        ST_CALC = 2'd2,
        ST_EMIT = 2'd3
    } t_state;

    // Weight of decimal position idx, most significant position first.
    function automatic logic [VALUE_W-1:0] pow10(input logic [IDX_W-1:0] idx);
        logic [VALUE_W-1:0] p;
        case (idx)
            4'd0:    p = 32'd1000000000;
            4'd1:    p = 32'd100000000;
            4'd2:    p = 32'd10000000;
            4'd3:    p = 32'd1000000;
            4'd4:    p = 32'd100000;
            4'd5:    p = 32'd10000;
            4'd6:    p = 32'd1000;
            4'd7:    p = 32'd100;
            4'd8:    p = 32'd10;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b2da_in_if.sv
// ----------------------------------------------------------------------------
// b2da_in_if
// Valid/ready channel carrying one value and its format code per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2da_in_if
    import b2da_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [OP_W-1:0]    operation;

    modport source (output valid, output value, output operation, input ready);
    modport sink   (input valid, input value, input operation, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/b2da_out_if.sv
// ----------------------------------------------------------------------------
// b2da_out_if
// Valid/ready channel carrying one ASCII character and a last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2da_out_if
    import b2da_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/b2da_sub_unit.sv
// ----------------------------------------------------------------------------
// b2da_sub_unit
// Shared trial subtractor: compares the remainder against a power of ten
// scaled by 1, 2, 4 or 8 and returns the reduced remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_sub_unit
    import b2da_pkg::*;
(
    input  wire logic [VALUE_W-1:0] i_rem,
    input  wire logic [IDX_W-1:0]   i_idx,
    input  wire logic [SHIFT_W-1:0] i_shift,
    output logic                    o_ge,
    output logic [VALUE_W-1:0]      o_diff
);

    // Eight times one billion needs 33 bits; one more bit holds the borrow.
    logic [VALUE_W+1:0] w_weight;
    logic [VALUE_W+2:0] w_trial;

    always_comb begin
        w_weight = {2'b00, pow10(i_idx)} << i_shift;
        w_trial  = {3'b000, i_rem} - {1'b0, w_weight};
        o_ge     = ~w_trial[VALUE_W+2];
        o_diff   = w_trial[VALUE_W-1:0];
    end

endmodule

`default_nettype wire

// File: hw/rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 32-bit value to decimal ASCII characters, most significant first.
// ----------------------------------------------------------------------------
//  Channel | Dir | Fields                          | Beat
//  i_in    | in  | value[31:0], operation[2:0]      | one value to convert
//  o_out   | out | character[7:0], last             | one character
//
//  Each digit is built by restoring compare-subtract in the shared
//  subtractor, trying 8, 4, 2 and 1 times the power of ten in turn, and is
//  then handed out as a character. Free formats still run the compare-
//  subtract for each leading zero that they skip.
//  i_in.ready is high only while idle; output stalls simply hold the block.
//  Reset returns the sequencer to idle; there is no state to clear.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii
    import b2da_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b2da_in_if.sink     i_in,
    b2da_out_if.source  o_out
);

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_rem, n_rem;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [SHIFT_W-1:0]  r_shift, n_shift;
    logic [DIGIT_W-1:0]  r_dig, n_dig;
    logic [CHAR_W-1:0]   r_sign_char, n_sign_char;
    logic                r_free, n_free;
    logic                r_seen, n_seen;

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_ge;
    logic [VALUE_W-1:0]  w_diff;
    logic [DIGIT_W-1:0]  w_dig_next;
    logic                w_skip;

    // Values decoded from the incoming beat.
    logic [VALUE_W-1:0]  w_mag;
    logic [IDX_W-1:0]    w_start_idx;
    logic                w_has_sign;
    logic                w_neg;

    b2da_sub_unit u_sub (
        .i_rem   (r_rem),
        .i_idx   (r_idx),
        .i_shift (r_shift),
        .o_ge    (w_ge),
        .o_diff  (w_diff)
    );

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_dig_next = {r_dig[DIGIT_W-2:0], w_ge};
    // A leading zero in a free format is dropped, but the units digit never is.
    assign w_skip     = r_free && !r_seen && (w_dig_next == '0) && (r_idx != IDX_LAST);

    always_comb begin
        w_mag       = i_in.value;
        w_start_idx = IDX_S32;
        w_has_sign  = 1'b0;
        w_neg       = 1'b0;
        case (t_op'(i_in.operation))
            OP_U8: begin
                w_mag       = {24'd0, i_in.value[7:0]};
                w_start_idx = IDX_S8;
            end
            OP_S8: begin
                w_neg       = i_in.value[7];
                w_mag       = w_neg ? {24'd0, 8'(-i_in.value[7:0])}
                                    : {24'd0, i_in.value[7:0]};
                w_start_idx = IDX_S8;
                w_has_sign  = 1'b1;
            end
            OP_U16: begin
                w_mag       = {16'd0, i_in.value[15:0]};
                w_start_idx = IDX_S16;
            end
            OP_S16: begin
                w_neg       = i_in.value[15];
                w_mag       = w_neg ? {16'd0, 16'(-i_in.value[15:0])}
                                    : {16'd0, i_in.value[15:0]};
                w_start_idx = IDX_S16;
                w_has_sign  = 1'b1;
            end
            OP_U32, OP_UFREE: begin
                w_mag       = i_in.value;
            end
            OP_S32: begin
                w_neg       = i_in.value[31];
                w_mag       = w_neg ? -i_in.value : i_in.value;
                w_has_sign  = 1'b1;
            end
            OP_SFREE: begin
                w_neg       = i_in.value[31];
                w_mag       = w_neg ? -i_in.value : i_in.value;
                w_has_sign  = w_neg;
            end
            default: begin
                w_mag       = i_in.value;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_has_sign ? ST_SIGN : ST_CALC;
                end
            end
            ST_SIGN: begin
                if (w_out_acc) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_shift == '0 && !w_skip) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    n_state = (r_idx == IDX_LAST) ? ST_IDLE : ST_CALC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_shift     = r_shift;
        n_dig       = r_dig;
        n_sign_char = r_sign_char;
        n_free      = r_free;
        n_seen      = r_seen;

        i_in.ready      = 1'b0;
        o_out.valid     = 1'b0;
        o_out.character = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, r_dig};
        o_out.last      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (w_in_acc) begin
                    n_rem       = w_mag;
                    n_idx       = w_start_idx;
                    n_shift     = '1;
                    n_dig       = '0;
                    n_sign_char = w_neg ? CHAR_MINUS : CHAR_SPACE;
                    n_free      = (t_op'(i_in.operation) == OP_UFREE) ||
                                  (t_op'(i_in.operation) == OP_SFREE);
                    n_seen      = 1'b0;
                end
            end
            ST_SIGN: begin
                o_out.valid     = 1'b1;
                o_out.character = r_sign_char;
            end
            ST_CALC: begin
                n_dig   = w_dig_next;
                n_shift = r_shift - 1'b1;
                if (w_ge) begin
                    n_rem = w_diff;
                end
                if (r_shift == '0) begin
                    if (w_skip) begin
                        n_idx = r_idx + 1'b1;
                        n_dig = '0;
                    end else begin
                        n_seen = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                o_out.valid = 1'b1;
                o_out.last  = (r_idx == IDX_LAST);
                if (w_out_acc && r_idx != IDX_LAST) begin
                    n_idx   = r_idx + 1'b1;
                    n_shift = '1;
                    n_dig   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_idx       <= n_idx;
        r_shift     <= n_shift;
        r_dig       <= n_dig;
        r_sign_char <= n_sign_char;
        r_free      <= n_free;
        r_seen      <= n_seen;
    end

endmodule

`default_nettype wire

// File: hw/rtl/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker
// Port-level checks on the converter's channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_checker
    import b2da_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [CHAR_W-1:0] i_out_character,
    input wire logic              i_out_last
);

    // The converter never takes a new value while characters are pending.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a character is offered");

    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after accepting a value");

    a_last_ends_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("character offered right after the last beat");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_character) && $stable(i_out_last)))
        else $error("stalled output beat changed");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_character (o_out.character),
    .i_out_last      (o_out.last)
);

`default_nettype wire
